### rtl/ppd_pkg.sv
// ----------------------------------------------------------------------------
// Periodic priority task dispatcher package
// Shared constants, operation and status codes, and word types.
// ----------------------------------------------------------------------------
package ppd_pkg;

   localparam int TASK_SLOTS_DEF = 16;
   localparam logic [31:0] STATS_WINDOW = 32'd5000;

   localparam logic [2:0] OP_ADD      = 3'd0;
   localparam logic [2:0] OP_TICK     = 3'd1;
   localparam logic [2:0] OP_DISPATCH = 3'd2;
   localparam logic [2:0] OP_START    = 3'd3;
   localparam logic [2:0] OP_STOP     = 3'd4;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_STOPPED = 2'd2;
   localparam logic [1:0] ST_NONE    = 2'd3;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  task_priority;
      logic [31:0] task_period;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        task_chosen;
      logic [3:0]  task_index;
      logic [4:0]  tasks_held;
      logic [31:0] dispatch_total;
      logic [31:0] idle_total;
      logic [31:0] time_now;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  prio;
      logic [31:0] period;
      logic [31:0] last_run;
      logic        completed;
   } entry_type;

   typedef struct packed {
      logic      done;
      logic      found;
      entry_type best;
   } scan_rsp_type;

endpackage

### rtl/ppd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ppd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ppd_scan.sv
// ----------------------------------------------------------------------------
// Dispatch scan unit
// Reads the task table one entry per cycle and keeps the best ready task.
// ----------------------------------------------------------------------------
module ppd_scan import ppd_pkg::*; #(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF,
   localparam int SLOT_W = $clog2(TASK_SLOTS),
   localparam int CNT_W = $clog2(TASK_SLOTS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CNT_W-1:0]  count,
   input  logic [31:0]       tick_time,
   output logic              rd_en,
   output logic [SLOT_W-1:0] rd_addr,
   input  entry_type         rd_data,
   output scan_rsp_type      result,
   output logic [SLOT_W-1:0] best_index
);

   logic              active_ff, active_in;
   logic [SLOT_W-1:0] addr_ff, addr_in;
   logic [SLOT_W-1:0] last_addr_ff, last_addr_in;
   logic              pend_ff, pend_in;
   logic              plast_ff, plast_in;
   logic [SLOT_W-1:0] pidx_ff, pidx_in;
   logic              found_ff, found_in;
   entry_type         best_ff, best_in;
   logic [SLOT_W-1:0] best_idx_ff, best_idx_in;
   logic              done_ff, done_in;

   logic [CNT_W-1:0]  count_m1;
   logic [31:0]       elapsed;
   logic              eligible;
   logic              better;

   always_comb begin
      count_m1 = count - CNT_W'(1);
      elapsed  = tick_time - rd_data.last_run;
      eligible = !rd_data.completed && (elapsed >= rd_data.period);
      better   = !found_ff || (rd_data.prio < best_ff.prio);

      active_in    = active_ff;
      addr_in      = addr_ff;
      last_addr_in = last_addr_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;

      if (start) begin
         active_in    = (count != '0);
         addr_in      = '0;
         found_in     = 1'b0;
         last_addr_in = count_m1[SLOT_W-1:0];
      end else if (active_ff) begin
         addr_in = addr_ff + SLOT_W'(1);
         if (addr_ff == last_addr_ff) begin
            active_in = 1'b0;
         end
      end

      pend_in  = active_ff;
      pidx_in  = addr_ff;
      plast_in = (addr_ff == last_addr_ff);

      if (pend_ff && eligible && better) begin
         found_in    = 1'b1;
         best_in     = rd_data;
         best_idx_in = pidx_ff;
      end

      done_in = (start && (count == '0)) || (pend_ff && plast_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         found_ff  <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
         found_ff  <= found_in;
         done_ff   <= done_in;
      end
      addr_ff      <= addr_in;
      last_addr_ff <= last_addr_in;
      plast_ff     <= plast_in;
      pidx_ff      <= pidx_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
   end

   assign rd_en        = active_ff;
   assign rd_addr      = addr_ff;
   assign result.done  = done_ff;
   assign result.found = found_ff;
   assign result.best  = best_ff;
   assign best_index   = best_idx_ff;

endmodule

### rtl/periodic_priority_task_dispatcher.sv
// ----------------------------------------------------------------------------
// Periodic priority task dispatcher
// Task table in RAM, tick counter, running flag and dispatch statistics.
// ----------------------------------------------------------------------------
// Add, tick, start, stop, unused codes and a dispatch while stopped go from
// the idle state straight to the finish state, which registers the response
// word. A dispatch while running first reads the task table once in the scan
// state, one entry per cycle through the single RAM read port. One word is in
// work at a time; a new request word is taken while the previous response
// word still waits.
// ----------------------------------------------------------------------------
module periodic_priority_task_dispatcher import ppd_pkg::*; #(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int SLOT_W = $clog2(TASK_SLOTS);
   localparam int CNT_W = $clog2(TASK_SLOTS + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [31:0]      tick_ff, tick_in;
   logic             running_ff, running_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      disp_ff, disp_in;
   logic [31:0]      idle_ff, idle_in;
   logic [31:0]      mark_ff, mark_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              scan_start;
   scan_rsp_type      scan_rsp;
   logic [SLOT_W-1:0] best_index;
   logic              ram_rd_en;
   logic [SLOT_W-1:0] ram_rd_addr;
   entry_type         ram_rd_data;
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_wr_addr;
   entry_type         ram_wr_data;

   logic              load_res;
   logic [1:0]        status_v;
   logic              chosen_v;
   logic [SLOT_W-1:0] index_v;
   logic [SLOT_W+3:0] index_ext;
   logic [CNT_W+4:0]  count_ext;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      running_in   = running_ff;
      count_in     = count_ff;
      disp_in      = disp_ff;
      idle_in      = idle_ff;
      mark_in      = mark_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      scan_start   = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = count_ff[SLOT_W-1:0];
      ram_wr_data  = '{prio: req_data.task_priority, period: req_data.task_period,
                       last_run: 32'd0, completed: 1'b0};
      load_res     = 1'b0;
      status_v     = ST_DONE;
      chosen_v     = 1'b0;
      index_v      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               load_res = 1'b1;
               state_in = S_FINISH;
               case (req_data.operation)
                  OP_ADD: begin
                     if (count_ff == CNT_W'(TASK_SLOTS)) begin
                        status_v = ST_FULL;
                     end else begin
                        ram_wr_en = 1'b1;
                        index_v   = count_ff[SLOT_W-1:0];
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  OP_TICK: begin
                     tick_in = tick_ff + 32'd1;
                  end
                  OP_DISPATCH: begin
                     if (!running_ff) begin
                        status_v = ST_STOPPED;
                     end else begin
                        scan_start = 1'b1;
                        load_res   = 1'b0;
                        state_in   = S_SCAN;
                     end
                  end
                  OP_START: begin
                     if (!running_ff) begin
                        running_in = 1'b1;
                        tick_in    = 32'd0;
                     end
                  end
                  OP_STOP: begin
                     running_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan_rsp.done) begin
               load_res = 1'b1;
               state_in = S_FINISH;
               if (scan_rsp.found) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = best_index;
                  ram_wr_data = '{prio: scan_rsp.best.prio, period: scan_rsp.best.period,
                                  last_run: tick_ff,
                                  completed: (scan_rsp.best.period == 32'd0)};
                  disp_in     = disp_ff + 32'd1;
                  chosen_v    = 1'b1;
                  index_v     = best_index;
               end else begin
                  idle_in  = idle_ff + 32'd1;
                  status_v = ST_NONE;
               end
               if ((tick_ff - mark_ff) >= STATS_WINDOW) begin
                  mark_in = tick_ff;
                  idle_in = 32'd0;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      index_ext = {4'd0, index_v};
      count_ext = {5'd0, count_in};
      res_in    = res_ff;
      if (load_res) begin
         res_in.status         = status_v;
         res_in.task_chosen    = chosen_v;
         res_in.task_index     = index_ext[3:0];
         res_in.tasks_held     = count_ext[4:0];
         res_in.dispatch_total = disp_in;
         res_in.idle_total     = idle_in;
         res_in.time_now       = tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_ff      <= 32'd0;
         running_ff   <= 1'b0;
         count_ff     <= '0;
         disp_ff      <= 32'd0;
         idle_ff      <= 32'd0;
         mark_ff      <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         running_ff   <= running_in;
         count_ff     <= count_in;
         disp_ff      <= disp_in;
         idle_ff      <= idle_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ppd_scan #(
      .TASK_SLOTS(TASK_SLOTS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (scan_start),
      .count     (count_ff),
      .tick_time (tick_ff),
      .rd_en     (ram_rd_en),
      .rd_addr   (ram_rd_addr),
      .rd_data   (ram_rd_data),
      .result    (scan_rsp),
      .best_index(best_index)
   );

   ppd_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(TASK_SLOTS)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   a_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_rsp.done |-> (state_ff == S_SCAN))
      else $error("Scan completion outside a dispatch.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TASK_SLOTS))
      else $error("Task count beyond table size.");

   a_write_source: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> accept || (state_ff == S_SCAN && scan_rsp.done && scan_rsp.found))
      else $error("Table written outside an add or a dispatch.");

   a_dispatch_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && scan_rsp.done && scan_rsp.found)
      |=> disp_ff == $past(disp_ff) + 32'd1)
      else $error("Dispatch total not advanced after a pick.");

   a_no_read_idle: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> (state_ff == S_SCAN))
      else $error("Table read outside a dispatch scan.");

endmodule

### tb/sv/ppd_checker.sv
// ----------------------------------------------------------------------------
// Periodic priority task dispatcher checker
// Watches the request and response channels, keeps its own copy of the task
// table, tick counter and statistics, predicts one response word for every
// accepted request word and compares each accepted response word with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module ppd_checker import ppd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   output int unsigned mismatch_count,
   output int unsigned words_outstanding,
   output int unsigned picks_predicted,
   output int unsigned window_clears
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 40;

   logic [31:0] tick_now;
   logic        sched_running;
   logic [4:0]  table_fill;
   entry_type   task_table [TASK_SLOTS_DEF];
   logic [31:0] dispatch_count;
   logic [31:0] idle_count;
   logic [31:0] window_mark;
   rsp_type     outcome_q [$];
   int unsigned fails = 0;
   int unsigned picks = 0;
   int unsigned clears = 0;

   initial begin
      mismatch_count    = 0;
      words_outstanding = 0;
      picks_predicted   = 0;
      window_clears     = 0;
   end

   function automatic rsp_type predict_outcome(req_type w);
      rsp_type     o;
      logic        found;
      logic [3:0]  best;
      logic [31:0] elapsed;
      o     = '0;
      found = 1'b0;
      best  = '0;
      case (w.operation)
         OP_ADD: begin
            if (table_fill >= TASK_SLOTS_DEF) begin
               o.status = ST_FULL;
            end else begin
               task_table[table_fill] = '{prio: w.task_priority, period: w.task_period,
                                          last_run: 32'd0, completed: 1'b0};
               o.task_index = table_fill[3:0];
               table_fill   = table_fill + 5'd1;
            end
         end
         OP_TICK: begin
            tick_now = tick_now + 32'd1;
         end
         OP_DISPATCH: begin
            if (!sched_running) begin
               o.status = ST_STOPPED;
            end else begin
               for (int k = 0; k < table_fill; k++) begin
                  elapsed = tick_now - task_table[k].last_run;
                  if (!task_table[k].completed && elapsed >= task_table[k].period &&
                      (!found || task_table[k].prio < task_table[best].prio)) begin
                     best  = 4'(k);
                     found = 1'b1;
                  end
               end
               if (found) begin
                  task_table[best].last_run = tick_now;
                  if (task_table[best].period == 32'd0) begin
                     task_table[best].completed = 1'b1;
                  end
                  dispatch_count = dispatch_count + 32'd1;
                  o.task_chosen  = 1'b1;
                  o.task_index   = best;
                  picks++;
               end else begin
                  idle_count = idle_count + 32'd1;
                  o.status   = ST_NONE;
               end
               elapsed = tick_now - window_mark;
               if (elapsed >= STATS_WINDOW) begin
                  window_mark = tick_now;
                  idle_count  = '0;
                  clears++;
               end
            end
         end
         OP_START: begin
            if (!sched_running) begin
               sched_running = 1'b1;
               tick_now      = '0;
            end
         end
         OP_STOP: begin
            sched_running = 1'b0;
         end
         default: begin
         end
      endcase
      o.tasks_held     = table_fill;
      o.dispatch_total = dispatch_count;
      o.idle_total     = idle_count;
      o.time_now       = tick_now;
      return o;
   endfunction

   task automatic report_mismatch(string what);
      fails++;
      if (fails <= PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         tick_now       = '0;
         sched_running  = 1'b0;
         table_fill     = '0;
         dispatch_count = '0;
         idle_count     = '0;
         window_mark    = '0;
         outcome_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            outcome_q.push_back(predict_outcome(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               report_mismatch("response word with no request word outstanding");
            end else begin
               want = outcome_q.pop_front();
               check_field("status", 32'(rsp_data.status), 32'(want.status));
               check_field("task_chosen", 32'(rsp_data.task_chosen), 32'(want.task_chosen));
               check_field("task_index", 32'(rsp_data.task_index), 32'(want.task_index));
               check_field("tasks_held", 32'(rsp_data.tasks_held), 32'(want.tasks_held));
               check_field("dispatch_total", rsp_data.dispatch_total, want.dispatch_total);
               check_field("idle_total", rsp_data.idle_total, want.idle_total);
               check_field("time_now", rsp_data.time_now, want.time_now);
            end
         end
      end
      mismatch_count    <= fails;
      words_outstanding <= outcome_q.size();
      picks_predicted   <= picks;
      window_clears     <= clears;
   end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Periodic priority task dispatcher testbench
// Drives directed request words and randomised scheduling traffic under
// several idle and stall mixes, including one long response hold-off, and
// gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top import ppd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          RESET_CYCLES   = 9;
   localparam int          RANDOM_WORDS   = 1124;
   localparam int          HOLD_CYCLES    = 400;
   localparam int          HOLD_AT_WORD   = 60;
   localparam int          DRAIN_CYCLES   = 32;
   localparam int          CYCLE_LIMIT    = 1_000_000;
   localparam logic [2:0]  OP_SPARE_FIRST = OP_STOP + 3'd1;
   localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   logic        hold_wanted   = 1'b0;
   logic        hold_taken    = 1'b0;
   int unsigned hold_left     = 0;
   int unsigned words_sent    = 0;
   int unsigned cycle_count   = 0;

   int unsigned mismatch_count;
   int unsigned words_outstanding;
   int unsigned picks_predicted;
   int unsigned window_clears;

   periodic_priority_task_dispatcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ppd_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data),
      .mismatch_count    (mismatch_count),
      .words_outstanding (words_outstanding),
      .picks_predicted   (picks_predicted),
      .window_clears     (window_clears)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // The receiver owns the hold-off counter; the stimulus only asks for it.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_wanted && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic req_type word_of(logic [2:0] op, logic [7:0] prio, logic [31:0] period);
      req_type w;
      w.operation     = op;
      w.task_priority = prio;
      w.task_period   = period;
      return w;
   endfunction

   function automatic req_type random_word();
      req_type     w;
      int unsigned pick;
      pick            = $urandom_range(99);
      w.task_priority = 8'($urandom());
      w.task_period   = $urandom();
      if (pick < 38) begin
         w.operation = OP_TICK;
      end else if (pick < 78) begin
         w.operation = OP_DISPATCH;
      end else if (pick < 88) begin
         w.operation = OP_ADD;
         if ($urandom_range(1) == 1) begin
            w.task_priority = 8'($urandom_range(3));
         end
         case ($urandom_range(9))
            0, 1: begin
            end
            2, 3, 4: begin
               w.task_period = $urandom_range(40, 7);
            end
            default: begin
               w.task_period = $urandom_range(6);
            end
         endcase
      end else if (pick < 94) begin
         w.operation = OP_START;
      end else if (pick < 97) begin
         w.operation = OP_STOP;
      end else begin
         w.operation = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      end
      return w;
   endfunction

   task automatic send_word(req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      words_sent++;
   endtask

   initial begin
      int unsigned send_mix [4];
      int unsigned stall_mix [4];
      send_mix  = '{0, 69, 0, 6};
      stall_mix = '{0, 0, 69, 6};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Stopped scheduler, spare codes, then an empty table and a first set of tasks.
      send_word(word_of(OP_DISPATCH, 8'hFF, 32'hFFFF_FFFF));
      for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) begin
         send_word(word_of(3'(c), 8'hFF, 32'hFFFF_FFFF));
      end
      send_word(word_of(OP_TICK, 8'h00, 32'h0));
      send_word(word_of(OP_STOP, 8'h00, 32'h0));
      send_word(word_of(OP_START, 8'h00, 32'h0));
      send_word(word_of(OP_DISPATCH, 8'h00, 32'h0));
      send_word(word_of(OP_ADD, 8'hFF, 32'hFFFF_FFFF));
      send_word(word_of(OP_ADD, 8'h00, 32'h0));
      send_word(word_of(OP_ADD, 8'h07, 32'd3));
      send_word(word_of(OP_ADD, 8'h07, 32'd3));
      send_word(word_of(OP_DISPATCH, 8'h00, 32'h0));
      send_word(word_of(OP_DISPATCH, 8'h00, 32'h0));
      repeat (3) send_word(word_of(OP_TICK, 8'h00, 32'h0));
      // Two equal priorities become due together: the lower index goes first.
      repeat (3) send_word(word_of(OP_DISPATCH, 8'h00, 32'h0));
      send_word(word_of(OP_START, 8'h00, 32'h0));
      send_word(word_of(OP_STOP, 8'h00, 32'h0));
      send_word(word_of(OP_DISPATCH, 8'h00, 32'h0));
      send_word(word_of(OP_START, 8'h00, 32'h0));
      send_word(word_of(OP_DISPATCH, 8'h00, 32'h0));

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = send_mix[ph];
         rsp_stall_pct <= stall_mix[ph];
         for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
            if (ph == 0 && n == HOLD_AT_WORD) begin
               hold_wanted <= 1'b1;
            end
            send_word(random_word());
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (words_outstanding != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request words: directed cases, then random traffic in four",
               words_sent);
      $display("idle and stall mixes with a long response hold-off; %0d picks, %0d clears.",
               picks_predicted, window_clears);
      if (mismatch_count == 0 && words_outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
